// ----- sv/fhss_pkg.sv -----
package fhss_pkg;

    // Table geometry.
    localparam int CHANNEL_COUNT = 20;
    localparam int BLOCK_COUNT   = 12;
    localparam int TABLE_LEN     = CHANNEL_COUNT * BLOCK_COUNT;
    localparam int SYNC_CH       = CHANNEL_COUNT / 2;
    localparam int SPAN          = CHANNEL_COUNT - 1;

    localparam int IDX_W = $clog2(TABLE_LEN);
    localparam int POS_W = $clog2(CHANNEL_COUNT);
    localparam int CH_W  = 7;

    // Generator constants.
    localparam logic [31:0] LCG_MUL   = 32'd214013;
    localparam logic [31:0] LCG_ADD   = 32'd2531011;
    localparam int          LCG_SHIFT = 16;
    localparam int          DRAW_W    = 32 - LCG_SHIFT;

    // Reciprocal for the draw modulo: floor(2^K / SPAN), one correction step.
    localparam int DRAW_K  = DRAW_W + $clog2(SPAN);
    localparam int DPROD_W = DRAW_W + DRAW_K;
    localparam logic [DRAW_K-1:0] DRAW_M = DRAW_K'((64'd1 << DRAW_K) / SPAN);

    // Reciprocal for the lookup index modulo the table length.
    localparam int HOP_W   = 8;
    localparam int LK_K    = HOP_W + IDX_W;
    localparam int LPROD_W = HOP_W + LK_K;
    localparam logic [LK_K-1:0] LK_M = LK_K'((64'd1 << LK_K) / TABLE_LEN);
    localparam int LK_W = ((IDX_W > HOP_W) ? IDX_W : HOP_W) + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FREQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 2'd1;
    localparam logic [31:0] BASE_FREQ_RESET = 32'd860000000;
    localparam logic [26:0] STEP_RESET      = 27'd1000000;

    // Operation codes.
    localparam logic OP_GENERATE = 1'b0;
    localparam logic OP_LOOKUP   = 1'b1;

    typedef struct packed {
        logic              op;
        logic [31:0]       seed_word;
        logic [HOP_W-1:0]  hop_index;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0] channel_number;
        logic [31:0]     frequency_hz;
        logic            is_lookup;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_SH_LCG,
        S_SH_MUL,
        S_SH_REM,
        S_SH_RD,
        S_SH_WR1,
        S_SH_WR2,
        S_LK_MUL,
        S_LK_REM,
        S_LK_RD,
        S_LK_FREQ,
        S_DONE
    } t_state;

endpackage

// ----- sv/fhss_hop_sequence_generator_top.sv -----
// Channel     Direction  Handshake                  Payload
// in          input      i_in_valid / o_in_stall    i_in_data  (fhss_pkg::t_in_item)
// out         output     o_out_valid / i_out_stall  o_out_data (fhss_pkg::t_out_item)
// cfg         input      i_cfg_we (no wait)         i_cfg_idx, i_cfg_data
//
// A lookup runs the reciprocal modulo (multiply, then remainder), one registered read
// of the table memory and one frequency multiply before the next acceptance.
// A generate makes one fill write per entry, then per swap the LCG step, the draw
// modulo (multiply, then remainder), one read of both entries and two writes through
// the single write port of the table memory.
// Reset is synchronous and active low; the table memory itself is not cleared.
// The finished result sits in an output register, so a stalled output only holds the
// block once the next result is ready.
module fhss_hop_sequence_generator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  fhss_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output fhss_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [fhss_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fhss_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import fhss_pkg::*;

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [IDX_W-1:0]     r_blk, n_blk;
    logic [31:0]          r_lcg, n_lcg;
    logic [DPROD_W-1:0]   r_dprod, n_dprod;
    logic [DRAW_W-1:0]    r_rem, n_rem;
    logic [IDX_W-1:0]     r_other, n_other;
    logic [HOP_W-1:0]     r_hop, n_hop;
    logic [LPROD_W-1:0]   r_lprod, n_lprod;
    logic [HOP_W-1:0]     r_lrem, n_lrem;
    t_out_item            r_res, n_res;
    t_out_item            r_out, n_out;
    logic                 r_out_valid, n_out_valid;
    logic [31:0]          r_base;
    logic [26:0]          r_step;

    // Hop table memory and its registered read ports.
    logic [CH_W-1:0]      mem [TABLE_LEN];
    logic [CH_W-1:0]      r_rd_a, r_rd_b;

    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    logic [CH_W-1:0]      w_wdata;
    logic                 w_rd_en;
    logic [IDX_W-1:0]     w_rd_addr_a, w_rd_addr_b;

    // Walk counters and their increments.
    logic                 w_last, w_pos_end;
    logic [IDX_W-1:0]     w_idx_inc, w_blk_inc;
    logic [POS_W-1:0]     w_pos_inc;

    // Datapath helpers.
    logic [CH_W-1:0]      w_fill;
    logic [DRAW_W-1:0]    w_draw_v, w_dq, w_draw_r;
    logic [IDX_W-1:0]     w_other;
    logic [HOP_W-1:0]     w_lq;
    logic [LK_W-1:0]      w_lk_ext, w_lk_fix;
    logic [IDX_W-1:0]     w_lk_idx;
    logic [31:0]          w_freq;
    logic                 w_load;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Counter stepping along the table.
    assign w_last    = (r_idx == IDX_W'(TABLE_LEN - 1));
    assign w_pos_end = (r_pos == POS_W'(CHANNEL_COUNT - 1));
    assign w_idx_inc = r_idx + 1'b1;
    assign w_pos_inc = w_pos_end ? '0 : r_pos + 1'b1;
    assign w_blk_inc = w_pos_end ? w_idx_inc : r_blk;

    // Initial block layout: sync channel at the start, zero at the sync position.
    always_comb begin
        if (r_pos == '0) begin
            w_fill = CH_W'(SYNC_CH);
        end else if (r_pos == POS_W'(SYNC_CH)) begin
            w_fill = '0;
        end else begin
            w_fill = CH_W'(r_pos);
        end
    end

    // Draw modulo SPAN via reciprocal, then a single correction.
    assign w_draw_v = r_lcg[31:LCG_SHIFT];
    assign w_dq     = r_dprod[DPROD_W-1:DRAW_K];
    assign w_draw_r = (r_rem >= DRAW_W'(SPAN)) ? r_rem - DRAW_W'(SPAN) : r_rem;
    assign w_other  = r_blk + IDX_W'(w_draw_r + 1'b1);

    // Lookup index modulo the table length, same scheme.
    assign w_lq     = r_lprod[LPROD_W-1:LK_K];
    assign w_lk_ext = LK_W'(r_lrem);
    assign w_lk_fix = (w_lk_ext >= LK_W'(TABLE_LEN)) ? w_lk_ext - LK_W'(TABLE_LEN)
                                                    : w_lk_ext;
    assign w_lk_idx = w_lk_fix[IDX_W-1:0];

    // Frequency of the channel just read.
    assign w_freq = r_base + 32'(r_rd_a) * 32'(r_step);

    // Next state and datapath control.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_blk       = r_blk;
        n_lcg       = r_lcg;
        n_dprod     = r_dprod;
        n_rem       = r_rem;
        n_other     = r_other;
        n_hop       = r_hop;
        n_lprod     = r_lprod;
        n_lrem      = r_lrem;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_we        = 1'b0;
        w_waddr     = r_idx;
        w_wdata     = w_fill;
        w_rd_en     = 1'b0;
        w_rd_addr_a = r_idx;
        w_rd_addr_b = r_other;
        w_load      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_idx = '0;
                    n_pos = '0;
                    n_blk = '0;
                    n_hop = i_in_data.hop_index;
                    if (i_in_data.op == OP_GENERATE) begin
                        n_lcg   = i_in_data.seed_word;
                        n_state = S_FILL;
                    end else begin
                        n_state = S_LK_MUL;
                    end
                end
            end
            S_FILL: begin
                w_we = 1'b1;
                if (w_last) begin
                    n_idx   = '0;
                    n_pos   = '0;
                    n_blk   = '0;
                    n_state = S_SH_LCG;
                end else begin
                    n_idx = w_idx_inc;
                    n_pos = w_pos_inc;
                    n_blk = w_blk_inc;
                end
            end
            S_SH_LCG: begin
                // Block starts are not shuffled and take no draw.
                if (r_pos == '0) begin
                    n_idx = w_idx_inc;
                    n_pos = w_pos_inc;
                    n_blk = w_blk_inc;
                end else begin
                    n_lcg   = r_lcg * LCG_MUL + LCG_ADD;
                    n_state = S_SH_MUL;
                end
            end
            S_SH_MUL: begin
                n_dprod = DPROD_W'(w_draw_v) * DPROD_W'(DRAW_M);
                n_state = S_SH_REM;
            end
            S_SH_REM: begin
                n_rem   = w_draw_v - DRAW_W'(w_dq * DRAW_W'(SPAN));
                n_state = S_SH_RD;
            end
            S_SH_RD: begin
                w_rd_en     = 1'b1;
                w_rd_addr_a = r_idx;
                w_rd_addr_b = w_other;
                n_other     = w_other;
                n_state     = S_SH_WR1;
            end
            S_SH_WR1: begin
                w_we    = 1'b1;
                w_waddr = r_idx;
                w_wdata = r_rd_b;
                n_state = S_SH_WR2;
            end
            S_SH_WR2: begin
                w_we    = 1'b1;
                w_waddr = r_other;
                w_wdata = r_rd_a;
                if (w_last) begin
                    n_res   = '0;
                    n_state = S_DONE;
                end else begin
                    n_idx   = w_idx_inc;
                    n_pos   = w_pos_inc;
                    n_blk   = w_blk_inc;
                    n_state = S_SH_LCG;
                end
            end
            S_LK_MUL: begin
                n_lprod = LPROD_W'(r_hop) * LPROD_W'(LK_M);
                n_state = S_LK_REM;
            end
            S_LK_REM: begin
                n_lrem  = r_hop - HOP_W'(LK_W'(w_lq) * LK_W'(TABLE_LEN));
                n_state = S_LK_RD;
            end
            S_LK_RD: begin
                w_rd_en     = 1'b1;
                w_rd_addr_a = w_lk_idx;
                n_state     = S_LK_FREQ;
            end
            S_LK_FREQ: begin
                n_res.channel_number = r_rd_a;
                n_res.frequency_hz   = w_freq;
                n_res.is_lookup      = 1'b1;
                n_state              = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Output register: load a finished result or drain a taken one.
        if (w_load) begin
            n_out       = r_res;
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_lcg       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_lcg       <= n_lcg;
        end
        r_idx   <= n_idx;
        r_pos   <= n_pos;
        r_blk   <= n_blk;
        r_dprod <= n_dprod;
        r_rem   <= n_rem;
        r_other <= n_other;
        r_hop   <= n_hop;
        r_lprod <= n_lprod;
        r_lrem  <= n_lrem;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_FREQ_RESET;
            r_step <= STEP_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_BASE_FREQ) begin
                r_base <= i_cfg_data[31:0];
            end else if (i_cfg_idx == CFG_STEP) begin
                r_step <= i_cfg_data[26:0];
            end
        end
    end

    // Table memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_rd_en) begin
            r_rd_a <= mem[w_rd_addr_a];
            r_rd_b <= mem[w_rd_addr_b];
        end
    end

    // An accepted transaction holds off the next one.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a transaction was in progress");

    // The second swap write always follows the first.
    a_swap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SH_WR2) |-> ($past(r_state) == S_SH_WR1))
        else $error("swap write out of sequence");

    // Memory writes stay inside the table.
    a_waddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (32'(w_waddr) < 32'(TABLE_LEN)))
        else $error("table write beyond its length");

    // A swap partner stays inside the block of the current entry.
    a_other_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SH_RD) |-> ((w_other > r_blk) &&
            (32'(w_other) < 32'(r_blk) + 32'(CHANNEL_COUNT))))
        else $error("swap partner outside its block");

    // Leaving the done state always presents a result.
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (!r_out_valid || !i_out_stall)) |=> o_out_valid)
        else $error("finished result was not presented");

endmodule
